[hdl/pspq_pkg.sv]
// Package for the process stack with priority run queue.
// Holds the payload structs, command, operation, status and back-end state codes, and default sizes.
// No dependencies.
`default_nettype none

package pspq_pkg;

    localparam int DEPTH_DEF   = 8;
    localparam int ID_BITS_DEF = 16;
    localparam int CMD_W       = 3;
    localparam int PID_W       = 16;
    localparam int PRI_W       = 4;
    localparam int STAT_W      = 3;

    localparam logic [CMD_W-1:0] CMD_ASSIGN  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_REMOVE  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_FREE    = 3'd2;
    localparam logic [CMD_W-1:0] CMD_LIST_Q  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_DRAIN   = 3'd4;
    localparam logic [CMD_W-1:0] CMD_LIST_S  = 3'd5;

    typedef enum logic [2:0] {
        OP_ASSIGN,
        OP_REMOVE,
        OP_FREE,
        OP_LIST_Q,
        OP_DRAIN,
        OP_LIST_S,
        OP_NOP
    } t_op;

    typedef enum logic [STAT_W-1:0] {
        STAT_DONE      = 3'd0,
        STAT_FULL      = 3'd1,
        STAT_NOT_FOUND = 3'd2,
        STAT_EMPTY     = 3'd3,
        STAT_LISTED    = 3'd4
    } t_status;

    typedef enum logic [3:0] {
        BK_IDLE,
        BK_EXEC,
        BK_INS_RD,
        BK_INS_CMP,
        BK_INS_WR,
        BK_SRCH_RD,
        BK_SRCH_CMP,
        BK_SHIFT_RD,
        BK_SHIFT_CMP,
        BK_LST_RD,
        BK_LST_EMIT,
        BK_REPLY
    } t_bk_state;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic [PID_W-1:0] proc_id;
        logic [PRI_W-1:0] proc_priority;
    } t_in;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [PID_W-1:0]  entry_id;
        logic [PRI_W-1:0]  entry_priority;
        logic              last;
    } t_out;

    typedef struct packed {
        t_op              op;
        logic [PID_W-1:0] id;
        logic [PRI_W-1:0] pri;
    } t_job;

    typedef struct packed {
        logic valid;
        t_job job;
    } t_job_link;

endpackage

`default_nettype wire

[hdl/pspq_front.sv]
// Front end: accepts input beats, decodes the command into an operation and
// buffers the decoded jobs in a two-entry queue for the back end.
// Depends on pspq_pkg.
`default_nettype none

module pspq_front (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire pspq_pkg::t_in     i_in_data,
    output pspq_pkg::t_job_link    o_job,
    input  wire logic              i_job_ready
);
    import pspq_pkg::*;

    t_job       r_buf [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_cnt;
    t_job       dec_job;
    logic       push;
    logic       pop;

    always_comb begin
        dec_job.id  = i_in_data.proc_id;
        dec_job.pri = i_in_data.proc_priority;
        case (i_in_data.cmd)
            CMD_ASSIGN: dec_job.op = OP_ASSIGN;
            CMD_REMOVE: dec_job.op = OP_REMOVE;
            CMD_FREE:   dec_job.op = OP_FREE;
            CMD_LIST_Q: dec_job.op = OP_LIST_Q;
            CMD_DRAIN:  dec_job.op = OP_DRAIN;
            CMD_LIST_S: dec_job.op = OP_LIST_S;
            default:    dec_job.op = OP_NOP;
        endcase
    end

    assign o_in_ready  = (r_cnt != 2'd2);
    assign push        = i_in_valid && o_in_ready;
    assign o_job.valid = (r_cnt != 2'd0);
    assign o_job.job   = r_buf[r_rd_ptr];
    assign pop         = o_job.valid && i_job_ready;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_buf[r_wr_ptr] <= dec_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_cnt    <= 2'd0;
        end else begin
            if (push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (pop && !push) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd2) |-> !o_in_ready)
        else $error("front queue accepts while full");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd0) |-> (r_wr_ptr == r_rd_ptr))
        else $error("front queue pointers disagree when empty");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && !pop) |=> (r_cnt != 2'd0))
        else $error("front queue lost a pushed job");

endmodule

`default_nettype wire

[hdl/pspq_back.sv]
// Back end: runs the decoded jobs against the stack and run queue memories
// and drives the result register. Depends on pspq_pkg.
`default_nettype none

module pspq_back #(
    parameter int DEPTH   = pspq_pkg::DEPTH_DEF,
    parameter int ID_BITS = pspq_pkg::ID_BITS_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire pspq_pkg::t_job_link i_job,
    output logic                   o_job_ready,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output pspq_pkg::t_out         o_out_data
);
    import pspq_pkg::*;

    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int ENT_W  = ID_BITS + PRI_W;
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);
    localparam logic [CNT_W-1:0] ONE      = CNT_W'(1);

    logic [ENT_W-1:0] r_stack [DEPTH];
    logic [ENT_W-1:0] r_queue [DEPTH];
    logic [ENT_W-1:0] r_rd_s;
    logic [ENT_W-1:0] r_rd_q;

    t_bk_state        r_state, n_state;
    t_job             r_job, n_job;
    logic             r_sel, n_sel;
    logic [CNT_W-1:0] r_idx, n_idx;
    logic [CNT_W-1:0] r_sc, n_sc;
    logic [CNT_W-1:0] r_qc, n_qc;
    t_status          r_stat, n_stat;
    logic             r_out_valid, n_out_valid;
    t_out             r_out, n_out;

    logic [CNT_W-1:0]  rd_idx;
    logic [CNT_W-1:0]  wr_idx;
    logic [ENT_W-1:0]  wr_data;
    logic              we_s;
    logic              we_q;
    logic [CNT_W-1:0]  cnt;
    logic [CNT_W-1:0]  idx_inc;
    logic [ENT_W-1:0]  rdata;
    logic [ENT_W-1:0]  job_ent;
    logic [31:0]       job_id_ext;
    logic [31:0]       ent_id_ext;
    logic              out_free;
    logic              out_load;

    assign job_id_ext = {16'd0, r_job.id};
    assign job_ent    = {job_id_ext[ID_BITS-1:0], r_job.pri};
    assign rdata      = r_sel ? r_rd_q : r_rd_s;
    assign ent_id_ext = 32'(rdata[ENT_W-1:PRI_W]);
    assign cnt        = r_sel ? r_qc : r_sc;
    assign idx_inc    = r_idx + ONE;
    assign out_free   = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (we_s) begin
            r_stack[wr_idx[ADDR_W-1:0]] <= wr_data;
        end
        if (we_q) begin
            r_queue[wr_idx[ADDR_W-1:0]] <= wr_data;
        end
        r_rd_s <= r_stack[rd_idx[ADDR_W-1:0]];
        r_rd_q <= r_queue[rd_idx[ADDR_W-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_IDLE;
            r_sc        <= '0;
            r_qc        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_sc        <= n_sc;
            r_qc        <= n_qc;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_job  <= n_job;
        r_sel  <= n_sel;
        r_idx  <= n_idx;
        r_stat <= n_stat;
        r_out  <= n_out;
    end

    always_comb begin
        n_state     = r_state;
        n_job       = r_job;
        n_sel       = r_sel;
        n_idx       = r_idx;
        n_sc        = r_sc;
        n_qc        = r_qc;
        n_stat      = r_stat;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_out_ready;
        out_load    = 1'b0;
        o_job_ready = 1'b0;
        rd_idx      = r_idx;
        wr_idx      = r_idx;
        wr_data     = rdata;
        we_s        = 1'b0;
        we_q        = 1'b0;

        case (r_state)
            BK_IDLE: begin
                o_job_ready = 1'b1;
                if (i_job.valid) begin
                    n_job   = i_job.job;
                    n_state = BK_EXEC;
                end
            end
            BK_EXEC: begin
                n_idx  = '0;
                n_stat = STAT_DONE;
                case (r_job.op)
                    OP_ASSIGN: begin
                        if (r_sc == FULL_CNT) begin
                            n_stat  = STAT_FULL;
                            n_state = BK_REPLY;
                        end else begin
                            we_s    = 1'b1;
                            wr_idx  = r_sc;
                            wr_data = job_ent;
                            n_sc    = r_sc + ONE;
                            n_sel   = 1'b1;
                            n_idx   = r_qc;
                            n_state = (r_qc == FULL_CNT) ? BK_REPLY : BK_INS_RD;
                        end
                    end
                    OP_REMOVE: begin
                        n_sel = 1'b0;
                        if (r_sc == '0) begin
                            n_stat  = STAT_EMPTY;
                            n_state = BK_REPLY;
                        end else begin
                            n_state = BK_SRCH_RD;
                        end
                    end
                    OP_FREE: begin
                        n_state = BK_REPLY;
                        if (r_sc == '0) begin
                            n_stat = STAT_EMPTY;
                        end else begin
                            n_sc = '0;
                            n_qc = '0;
                        end
                    end
                    OP_LIST_Q, OP_DRAIN: begin
                        n_sel = 1'b1;
                        if (r_qc == '0) begin
                            n_stat  = STAT_EMPTY;
                            n_state = BK_REPLY;
                        end else begin
                            n_state = BK_LST_RD;
                        end
                    end
                    OP_LIST_S: begin
                        n_sel = 1'b0;
                        if (r_sc == '0) begin
                            n_stat  = STAT_EMPTY;
                            n_state = BK_REPLY;
                        end else begin
                            n_state = BK_LST_RD;
                        end
                    end
                    default: begin
                        n_state = BK_REPLY;
                    end
                endcase
            end
            BK_INS_RD: begin
                rd_idx = r_idx - ONE;
                n_state = (r_idx == '0) ? BK_INS_WR : BK_INS_CMP;
            end
            BK_INS_CMP: begin
                if (r_rd_q[PRI_W-1:0] < r_job.pri) begin
                    we_q    = 1'b1;
                    wr_data = r_rd_q;
                    n_idx   = r_idx - ONE;
                    n_state = BK_INS_RD;
                end else begin
                    n_state = BK_INS_WR;
                end
            end
            BK_INS_WR: begin
                we_q    = 1'b1;
                wr_data = job_ent;
                n_qc    = r_qc + ONE;
                n_stat  = STAT_DONE;
                n_state = BK_REPLY;
            end
            BK_SRCH_RD: begin
                if (r_idx == cnt) begin
                    n_stat  = r_sel ? STAT_DONE : STAT_NOT_FOUND;
                    n_state = BK_REPLY;
                end else begin
                    n_state = BK_SRCH_CMP;
                end
            end
            BK_SRCH_CMP: begin
                if (rdata[ENT_W-1:PRI_W] == job_id_ext[ID_BITS-1:0]) begin
                    n_state = BK_SHIFT_RD;
                end else begin
                    n_idx   = idx_inc;
                    n_state = BK_SRCH_RD;
                end
            end
            BK_SHIFT_RD: begin
                rd_idx = idx_inc;
                if (idx_inc < cnt) begin
                    n_state = BK_SHIFT_CMP;
                end else if (r_sel) begin
                    n_qc    = r_qc - ONE;
                    n_stat  = STAT_DONE;
                    n_state = BK_REPLY;
                end else begin
                    n_sc    = r_sc - ONE;
                    n_sel   = 1'b1;
                    n_idx   = '0;
                    n_state = BK_SRCH_RD;
                end
            end
            BK_SHIFT_CMP: begin
                we_s    = !r_sel;
                we_q    = r_sel;
                n_idx   = idx_inc;
                n_state = BK_SHIFT_RD;
            end
            BK_LST_RD: begin
                n_state = BK_LST_EMIT;
            end
            BK_LST_EMIT: begin
                if (out_free) begin
                    out_load             = 1'b1;
                    n_out_valid          = 1'b1;
                    n_out.status         = STAT_LISTED;
                    n_out.entry_id       = ent_id_ext[PID_W-1:0];
                    n_out.entry_priority = rdata[PRI_W-1:0];
                    n_out.last           = (idx_inc == cnt);
                    n_idx                = idx_inc;
                    if (idx_inc == cnt) begin
                        if (r_job.op == OP_DRAIN) begin
                            n_qc = '0;
                        end
                        n_state = BK_IDLE;
                    end else begin
                        n_state = BK_LST_RD;
                    end
                end
            end
            BK_REPLY: begin
                if (out_free) begin
                    out_load             = 1'b1;
                    n_out_valid          = 1'b1;
                    n_out.status         = r_stat;
                    n_out.entry_id       = '0;
                    n_out.entry_priority = '0;
                    n_out.last           = 1'b1;
                    n_state              = BK_IDLE;
                end
            end
            default: begin
                n_state = BK_IDLE;
            end
        endcase
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_sc <= FULL_CNT) && (r_qc <= FULL_CNT))
        else $error("store count beyond depth");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == BK_INS_RD) |-> (r_qc < FULL_CNT))
        else $error("queue insertion started on a full queue");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_load && n_out.last) |=> (r_state == BK_IDLE))
        else $error("final result did not end the job");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == BK_LST_EMIT) |-> (r_idx < cnt))
        else $error("listing ran past the store count");

endmodule

`default_nettype wire

[hdl/process_stack_priority_run_queue.sv]
// Top level of the process stack with priority run queue.
// Instantiates pspq_front and pspq_back; depends on pspq_pkg.
//
//   channel   direction   handshake                      payload
//   input     in          i_in_valid / o_in_ready        i_in_data  (t_in)
//   result    out         o_out_valid / i_out_ready      o_out_data (t_out)
//
// The front takes a beat whenever its two-entry job queue has room.
// The back runs one job at a time through a single read port per store with
// registered read data: each entry searched, moved or listed takes a read state
// and then a compare, move or emit state. An assign shifts lower-priority queue
// entries to make room; a list or drain emits one result per entry.
// Reset is synchronous and empties both stores; a stalled result holds the back.
`default_nettype none

module process_stack_priority_run_queue #(
    parameter int DEPTH   = pspq_pkg::DEPTH_DEF,
    parameter int ID_BITS = pspq_pkg::ID_BITS_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    input  wire pspq_pkg::t_in i_in_data,
    output logic               o_out_valid,
    input  wire logic          i_out_ready,
    output pspq_pkg::t_out     o_out_data
);
    import pspq_pkg::*;

    t_job_link job_link;
    logic      job_ready;

    pspq_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_job       (job_link),
        .i_job_ready (job_ready)
    );

    pspq_back #(
        .DEPTH   (DEPTH),
        .ID_BITS (ID_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job       (job_link),
        .o_job_ready (job_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

`default_nettype wire
